// ===== src/ptt_pkg.sv =====
package ptt_pkg;

    localparam int KIND_W        = 2;
    localparam int ID_W          = 31;
    localparam int TIME_W        = 32;
    localparam int DEF_NUM_SLOTS = 16;
    localparam int MAX_RES       = 16;
    localparam int EMIT_W        = $clog2(MAX_RES);

    localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD  = 2'd0,
        KIND_DEL  = 2'd1,
        KIND_UPD  = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ID_W-1:0]   interval;
        logic              rpt;
        logic [TIME_W-1:0] elapsed;
    } slot_t;

    typedef struct packed {
        logic [TIME_W-1:0] add_a;
        logic [TIME_W-1:0] add_b;
        logic [TIME_W-1:0] sub_a;
        logic [TIME_W-1:0] sub_b;
    } calc_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] sat_sum;
        logic [TIME_W-1:0] diff;
        logic              borrow;
        logic              zero;
    } calc_rsp_t;

endpackage

// ===== src/periodic_timer_table.sv =====
// periodic timer table
// command channel: an item is taken at a clock edge with start high and busy low.
// kind selects add (interval, repeat_req), delete (task_id) or time update
// (timestamp). every item gives one or more results on kind_res, timer_id, ok
// and last, each shown for exactly one cycle while result_strobe is high; the
// final result of an item has last set. the receiver cannot stall the block.
// add, unused kind and an update that is not ahead of the last time give
// their result in the cycle after the item is taken, with busy staying low.
// delete walks the slot memory at one slot a cycle until it finds the id.
// update walks all slots through a two-stage saturating add and subtract, then
// picks each fired id by a compare walk over the slot memory, ascending, at
// most 16 results.
// busy is high until the last result of the item has been decided.
// reset: all slots free, id seed and last time zero; no clearing pass needed.
module periodic_timer_table
    import ptt_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [KIND_W-1:0] kind,
    input  logic [ID_W-1:0]   interval,
    input  logic              repeat_req,
    input  logic [ID_W-1:0]   task_id,
    input  logic [TIME_W-1:0] timestamp,
    output logic              result_strobe,
    output logic [KIND_W-1:0] kind_res,
    output logic [ID_W-1:0]   timer_id,
    output logic              ok,
    output logic              last
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DEL  = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_SEL  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [NUM_SLOTS-1:0]   valid_reg, valid_next;
    logic [NUM_SLOTS-1:0]   fired_reg, fired_next;
    logic [ID_W-1:0]        seed_reg, seed_next;
    logic [TIME_W-1:0]      last_time_reg, last_time_next;
    logic [TIME_W-1:0]      diff_reg, diff_next;
    logic [ID_W-1:0]        task_id_reg, task_id_next;
    logic [CNT_W-1:0]       scan_reg, scan_next;
    logic                   p1_v_reg, p1_v_next;
    logic [IDX_W-1:0]       p1_idx_reg, p1_idx_next;
    logic                   p1_last_reg, p1_last_next;
    logic                   p2_v_reg, p2_v_next;
    logic [IDX_W-1:0]       p2_idx_reg, p2_idx_next;
    logic                   p2_last_reg, p2_last_next;
    slot_t                  p2_slot_reg, p2_slot_next;
    logic                   have_best_reg, have_best_next;
    logic [ID_W-1:0]        best_id_reg, best_id_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [EMIT_W-1:0]      emit_cnt_reg, emit_cnt_next;
    logic                   strobe_reg, strobe_next;
    logic [KIND_W-1:0]      kind_res_reg, kind_res_next;
    logic [ID_W-1:0]        timer_id_reg, timer_id_next;
    logic                   ok_reg, ok_next;
    logic                   last_reg, last_next;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    slot_t                  ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    slot_t                  rd_slot;

    calc_req_t              calc_req;
    calc_rsp_t              calc_rsp;

    logic                   free_found;
    logic [IDX_W-1:0]       free_idx;
    logic                   scan_issue;
    logic                   scan_last;
    logic                   fire;
    logic                   sel_take;
    logic                   sel_have;
    logic [ID_W-1:0]        sel_id;
    logic [IDX_W-1:0]       sel_idx;
    logic [NUM_SLOTS-1:0]   sel_mask;
    logic                   sel_more;
    logic                   sel_final;

    ptt_slot_ram #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_slot)
    );

    ptt_calc u_calc (
        .req (calc_req),
        .rsp (calc_rsp)
    );

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign scan_issue = (scan_reg < CNT_W'(NUM_SLOTS));
    assign scan_last  = (scan_reg == CNT_W'(NUM_SLOTS - 1));
    assign fire       = !calc_rsp.borrow;

    // running minimum over fired slots
    assign sel_take = p1_v_reg && fired_reg[p1_idx_reg] && (!have_best_reg || calc_rsp.borrow);
    assign sel_have = have_best_reg || sel_take;
    assign sel_id   = sel_take ? rd_slot.id : best_id_reg;
    assign sel_idx  = sel_take ? p1_idx_reg : best_idx_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            sel_mask[i] = (IDX_W'(i) == sel_idx);
        end
    end

    assign sel_more  = |(fired_reg & ~sel_mask);
    assign sel_final = !sel_more || (emit_cnt_reg == EMIT_W'(MAX_RES - 1));

    // operand selection for the shared unit
    always_comb
    begin
        calc_req = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                calc_req.sub_a = timestamp;
                calc_req.sub_b = last_time_reg;
            end
            ST_DEL:
            begin
                calc_req.sub_a = {1'b0, rd_slot.id};
                calc_req.sub_b = {1'b0, task_id_reg};
            end
            ST_UPD:
            begin
                calc_req.add_a = rd_slot.elapsed;
                calc_req.add_b = diff_reg;
                calc_req.sub_a = p2_slot_reg.elapsed;
                calc_req.sub_b = {1'b0, p2_slot_reg.interval};
            end
            ST_SEL:
            begin
                calc_req.sub_a = {1'b0, rd_slot.id};
                calc_req.sub_b = {1'b0, best_id_reg};
            end
            default:
            begin
                calc_req = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        fired_next     = fired_reg;
        seed_next      = seed_reg;
        last_time_next = last_time_reg;
        diff_next      = diff_reg;
        task_id_next   = task_id_reg;
        scan_next      = scan_reg;
        p1_v_next      = 1'b0;
        p1_idx_next    = scan_reg[IDX_W-1:0];
        p1_last_next   = 1'b0;
        p2_v_next      = 1'b0;
        p2_idx_next    = p1_idx_reg;
        p2_last_next   = p1_last_reg;
        p2_slot_next   = rd_slot;
        p2_slot_next.elapsed = calc_rsp.sat_sum;
        have_best_next = have_best_reg;
        best_id_next   = best_id_reg;
        best_idx_next  = best_idx_reg;
        emit_cnt_next  = emit_cnt_reg;
        strobe_next    = 1'b0;
        kind_res_next  = kind_res_reg;
        timer_id_next  = timer_id_reg;
        ok_next        = ok_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_waddr      = p2_idx_reg;
        ram_wdata      = p2_slot_reg;
        ram_wdata.elapsed = fire ? calc_rsp.diff : p2_slot_reg.elapsed;
        ram_raddr      = scan_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (kind_t'(kind))
                        KIND_ADD:
                        begin
                            strobe_next   = 1'b1;
                            kind_res_next = KIND_ADD;
                            last_next     = 1'b1;
                            if (interval == '0 || !free_found || seed_reg == ID_MAX)
                            begin
                                timer_id_next = '0;
                                ok_next       = 1'b0;
                            end
                            else
                            begin
                                seed_next            = seed_reg + ID_W'(1);
                                ram_we               = 1'b1;
                                ram_waddr            = free_idx;
                                ram_wdata.id         = seed_reg + ID_W'(1);
                                ram_wdata.interval   = interval;
                                ram_wdata.rpt        = repeat_req;
                                ram_wdata.elapsed    = '0;
                                valid_next[free_idx] = 1'b1;
                                timer_id_next        = seed_reg + ID_W'(1);
                                ok_next              = 1'b1;
                            end
                        end
                        KIND_DEL:
                        begin
                            task_id_next = task_id;
                            scan_next    = '0;
                            state_next   = ST_DEL;
                        end
                        KIND_UPD:
                        begin
                            if (calc_rsp.zero || calc_rsp.diff[TIME_W-1])
                            begin
                                strobe_next   = 1'b1;
                                kind_res_next = KIND_UPD;
                                timer_id_next = '0;
                                ok_next       = 1'b0;
                                last_next     = 1'b1;
                            end
                            else
                            begin
                                last_time_next = timestamp;
                                diff_next      = calc_rsp.diff;
                                fired_next     = '0;
                                scan_next      = '0;
                                state_next     = ST_UPD;
                            end
                        end
                        KIND_NONE:
                        begin
                            strobe_next   = 1'b1;
                            kind_res_next = KIND_NONE;
                            timer_id_next = '0;
                            ok_next       = 1'b0;
                            last_next     = 1'b1;
                        end
                    endcase
                end
            end
            ST_DEL:
            begin
                if (scan_issue)
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
                p1_v_next    = scan_issue;
                p1_last_next = scan_issue && scan_last;
                if (p1_v_reg)
                begin
                    if (valid_reg[p1_idx_reg] && calc_rsp.zero)
                    begin
                        valid_next[p1_idx_reg] = 1'b0;
                        strobe_next   = 1'b1;
                        kind_res_next = KIND_DEL;
                        timer_id_next = '0;
                        ok_next       = 1'b1;
                        last_next     = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else if (p1_last_reg)
                    begin
                        strobe_next   = 1'b1;
                        kind_res_next = KIND_DEL;
                        timer_id_next = '0;
                        ok_next       = 1'b0;
                        last_next     = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            ST_UPD:
            begin
                if (scan_issue)
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
                p1_v_next    = scan_issue;
                p1_last_next = scan_issue && scan_last;
                p2_v_next    = p1_v_reg;
                // stage two: subtract interval on reaching it, write back
                if (p2_v_reg)
                begin
                    if (valid_reg[p2_idx_reg])
                    begin
                        ram_we = 1'b1;
                        if (fire)
                        begin
                            fired_next[p2_idx_reg] = 1'b1;
                            if (!p2_slot_reg.rpt)
                            begin
                                valid_next[p2_idx_reg] = 1'b0;
                            end
                        end
                    end
                    if (p2_last_reg)
                    begin
                        scan_next      = '0;
                        have_best_next = 1'b0;
                        emit_cnt_next  = '0;
                        state_next     = ST_SEL;
                    end
                end
            end
            ST_SEL:
            begin
                if (scan_issue)
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
                p1_v_next      = scan_issue;
                p1_last_next   = scan_issue && scan_last;
                have_best_next = sel_have;
                best_id_next   = sel_id;
                best_idx_next  = sel_idx;
                if (p1_v_reg && p1_last_reg)
                begin
                    strobe_next   = 1'b1;
                    kind_res_next = KIND_UPD;
                    if (!sel_have)
                    begin
                        timer_id_next = '0;
                        ok_next       = 1'b0;
                        last_next     = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        timer_id_next         = sel_id;
                        ok_next               = 1'b1;
                        last_next             = sel_final;
                        fired_next[sel_idx]   = 1'b0;
                        emit_cnt_next         = emit_cnt_reg + EMIT_W'(1);
                        have_best_next        = 1'b0;
                        scan_next             = '0;
                        if (sel_final)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            fired_reg     <= '0;
            seed_reg      <= '0;
            last_time_reg <= '0;
            scan_reg      <= '0;
            p1_v_reg      <= 1'b0;
            p1_last_reg   <= 1'b0;
            p2_v_reg      <= 1'b0;
            p2_last_reg   <= 1'b0;
            have_best_reg <= 1'b0;
            emit_cnt_reg  <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            fired_reg     <= fired_next;
            seed_reg      <= seed_next;
            last_time_reg <= last_time_next;
            scan_reg      <= scan_next;
            p1_v_reg      <= p1_v_next;
            p1_last_reg   <= p1_last_next;
            p2_v_reg      <= p2_v_next;
            p2_last_reg   <= p2_last_next;
            have_best_reg <= have_best_next;
            emit_cnt_reg  <= emit_cnt_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg     <= diff_next;
        task_id_reg  <= task_id_next;
        p1_idx_reg   <= p1_idx_next;
        p2_idx_reg   <= p2_idx_next;
        p2_slot_reg  <= p2_slot_next;
        best_id_reg  <= best_id_next;
        best_idx_reg <= best_idx_next;
        kind_res_reg <= kind_res_next;
        timer_id_reg <= timer_id_next;
        ok_reg       <= ok_next;
        last_reg     <= last_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_strobe = strobe_reg;
    assign kind_res      = kind_res_reg;
    assign timer_id      = timer_id_reg;
    assign ok            = ok_reg;
    assign last          = last_reg;

`ifndef SYNTH
    a_add_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && ok && kind_res == KIND_ADD |-> timer_id != '0)
        else $error("successful add returned id zero");

    a_more_results_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last |-> busy)
        else $error("non-final result while block is idle");

    a_single_cycle_items: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (kind == KIND_ADD || kind == KIND_NONE) |=> result_strobe && last)
        else $error("add or unused kind gave no final result next cycle");

    a_ram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE || state_reg == ST_UPD))
        else $error("slot memory written outside add or update pass");
`endif

endmodule

// ===== src/ptt_slot_ram.sv =====
module ptt_slot_ram
    import ptt_pkg::*;
#(
    parameter int DEPTH  = DEF_NUM_SLOTS,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  slot_t             wdata,
    input  logic [ADDR_W-1:0] raddr,
    output slot_t             rdata
);

    slot_t slot_mem [DEPTH];
    slot_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            slot_mem[waddr] <= wdata;
        end
        rdata_reg <= slot_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ptt_calc.sv =====
module ptt_calc
    import ptt_pkg::*;
(
    input  calc_req_t req,
    output calc_rsp_t rsp
);

    logic [TIME_W:0] sum_w;
    logic [TIME_W:0] dif_w;

    assign sum_w = {1'b0, req.add_a} + {1'b0, req.add_b};
    assign dif_w = {1'b0, req.sub_a} - {1'b0, req.sub_b};

    // saturating add, and a subtract whose borrow doubles as a compare
    assign rsp.sat_sum = sum_w[TIME_W] ? {TIME_W{1'b1}} : sum_w[TIME_W-1:0];
    assign rsp.diff    = dif_w[TIME_W-1:0];
    assign rsp.borrow  = dif_w[TIME_W];
    assign rsp.zero    = (dif_w[TIME_W-1:0] == '0);

endmodule
